[hw/rtl/hep_pkg.sv]
// Package: shared constants, codes and types of the Huffman encoder and 7-bit packer.
package hep_pkg;

    localparam int GROUP_BITS   = 7;
    localparam int MAX_CODE_LEN = 32;
    localparam int CODE_W       = 32;
    localparam int LEN_W        = 6;
    localparam int SYM_W        = 8;
    localparam int KIND_W       = 2;
    localparam int TBL_DEPTH    = 256;
    localparam int ACC_W        = GROUP_BITS - 1 + MAX_CODE_LEN;
    localparam int CNT_W        = $clog2(ACC_W + 1);

    localparam logic [KIND_W-1:0] KIND_LOAD   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_ENCODE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_FLUSH  = 2'd2;

    localparam logic [LEN_W-1:0] LEN_MAX    = LEN_W'(MAX_CODE_LEN);
    localparam logic [LEN_W-1:0] LEN_CODE_W = LEN_W'(CODE_W);
    localparam logic [CNT_W-1:0] CNT_GROUP  = CNT_W'(GROUP_BITS);
    localparam logic [CNT_W-1:0] CNT_ACC    = CNT_W'(ACC_W);

    typedef struct packed {
        logic [LEN_W-1:0]  len;
        logic [CODE_W-1:0] code;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

endpackage

[hw/rtl/hep_if.sv]
// Interfaces: input word channel and output character channel.
interface hep_in_if;
    logic                          valid;
    logic                          ready;
    logic [hep_pkg::KIND_W-1:0]    kind;
    logic [hep_pkg::SYM_W-1:0]     symbol;
    logic [hep_pkg::CODE_W-1:0]    code_bits;
    logic [hep_pkg::LEN_W-1:0]     code_len;

    modport source (output valid, kind, symbol, code_bits, code_len, input ready);
    modport sink   (input valid, kind, symbol, code_bits, code_len, output ready);
endinterface

interface hep_out_if;
    logic                              valid;
    logic                              ready;
    logic [hep_pkg::GROUP_BITS-1:0]    out_char;
    logic                              last;

    modport source (output valid, out_char, last, input ready);
    modport sink   (input valid, out_char, last, output ready);
endinterface

[hw/rtl/hep_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
module hep_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[hw/rtl/huffman_encode_pack_7bit_unit.sv]
// Top level: Huffman code-table encoder with 7-bit output character packing.
//
// i_in carries words of kind load (table entry at symbol), encode (look up
// symbol, append its code MSB first) or flush (pad pending bits with zeros).
// o_out carries 7-bit characters, earliest bit as MSB; last marks the final
// character caused by one input word. Both channels move a word when valid
// and ready are high at a rising edge.
// Pipeline: input stage with registered table read, then a bit accumulator
// that merges the code and emits one character per cycle into the output
// register while the receiver is ready. A word's first character passes the
// input stage, the accumulator and the output register in that order. A word
// yielding several characters holds the next word in the input stage until
// fewer than 7 bits are pending, since the single character-wide output
// register takes one character at a time.
// Reset clears all table entries (per-entry valid flags), the pending bits
// and the pipeline. When the receiver stalls, the output register holds its
// character, the accumulator stops emitting and i_in.ready drops once the
// input stage is full.
module huffman_encode_pack_7bit_unit (
    input  logic      i_clk,
    input  logic      i_rst_n,
    hep_in_if.sink    i_in,
    hep_out_if.source o_out
);

    logic                              in_acc;
    logic [hep_pkg::LEN_W-1:0]         w_len_sat;
    logic [hep_pkg::CODE_W-1:0]        w_mask;
    hep_pkg::t_entry                   w_entry;
    hep_pkg::t_entry                   a_entry;
    logic [hep_pkg::TBL_DEPTH-1:0]     r_tbl_vld;

    logic                              r_a_vld;
    logic [hep_pkg::KIND_W-1:0]        r_a_kind;
    logic                              r_a_hit;
    logic [hep_pkg::LEN_W-1:0]         a_len;

    logic [hep_pkg::ACC_W-1:0]         r_acc;
    logic [hep_pkg::CNT_W-1:0]         r_cnt;
    logic [hep_pkg::ACC_W-1:0]         n_acc;
    logic [hep_pkg::CNT_W-1:0]         n_cnt;
    logic [hep_pkg::CNT_W-1:0]         emit_rem;
    logic [hep_pkg::CNT_W-1:0]         rem_cnt;
    logic [hep_pkg::ACC_W-1:0]         rem_acc;
    logic                              out_free;
    logic                              emit;
    logic                              eng_free;
    logic                              a_move;

    logic                              r_o_vld;
    logic [hep_pkg::GROUP_BITS-1:0]    r_o_char;
    logic                              r_o_last;

    // table write: saturate length, drop code bits above it
    assign in_acc    = i_in.valid && i_in.ready;
    assign w_len_sat = (i_in.code_len > hep_pkg::LEN_MAX) ? hep_pkg::LEN_MAX : i_in.code_len;
    assign w_mask    = {hep_pkg::CODE_W{1'b1}} >> (hep_pkg::LEN_CODE_W - w_len_sat);
    assign w_entry   = '{len: w_len_sat, code: i_in.code_bits & w_mask};

    hep_ram #(
        .WIDTH (hep_pkg::ENTRY_W),
        .DEPTH (hep_pkg::TBL_DEPTH)
    ) u_tbl (
        .i_clk   (i_clk),
        .i_we    (in_acc && (i_in.kind == hep_pkg::KIND_LOAD)),
        .i_waddr (i_in.symbol),
        .i_wdata (w_entry),
        .i_re    (in_acc && (i_in.kind == hep_pkg::KIND_ENCODE)),
        .i_raddr (i_in.symbol),
        .o_rdata (a_entry)
    );

    assign a_len = r_a_hit ? a_entry.len : '0;

    // accumulator: emit one character, then merge the next word into the rest
    assign out_free = !r_o_vld || o_out.ready;
    assign emit     = (r_cnt >= hep_pkg::CNT_GROUP) && out_free;
    assign emit_rem = r_cnt - hep_pkg::CNT_GROUP;
    assign rem_cnt  = emit ? emit_rem : r_cnt;
    assign rem_acc  = r_acc & ~({hep_pkg::ACC_W{1'b1}} << rem_cnt);
    assign eng_free = rem_cnt < hep_pkg::CNT_GROUP;
    assign a_move   = r_a_vld && eng_free;

    assign i_in.ready = !r_a_vld || a_move;

    always_comb begin
        n_acc = rem_acc;
        n_cnt = rem_cnt;
        if (a_move) begin
            case (r_a_kind)
                hep_pkg::KIND_ENCODE: begin
                    if (a_len != '0) begin
                        n_acc = (rem_acc << a_len) | hep_pkg::ACC_W'(a_entry.code);
                        n_cnt = rem_cnt + hep_pkg::CNT_W'(a_len);
                    end
                end
                hep_pkg::KIND_FLUSH: begin
                    if (rem_cnt != '0) begin
                        n_acc = rem_acc << (hep_pkg::CNT_GROUP - rem_cnt);
                        n_cnt = hep_pkg::CNT_GROUP;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tbl_vld <= '0;
            r_a_vld   <= 1'b0;
            r_acc     <= '0;
            r_cnt     <= '0;
            r_o_vld   <= 1'b0;
        end else begin
            if (in_acc && (i_in.kind == hep_pkg::KIND_LOAD)) begin
                r_tbl_vld[i_in.symbol] <= 1'b1;
            end
            if (i_in.ready) begin
                r_a_vld <= i_in.valid;
            end
            r_acc <= n_acc;
            r_cnt <= n_cnt;
            if (out_free) begin
                r_o_vld <= emit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_a_kind <= i_in.kind;
            r_a_hit  <= r_tbl_vld[i_in.symbol];
        end
        if (emit) begin
            r_o_char <= hep_pkg::GROUP_BITS'(r_acc >> emit_rem);
            r_o_last <= emit_rem < hep_pkg::CNT_GROUP;
        end
    end

    assign o_out.valid    = r_o_vld;
    assign o_out.out_char = r_o_char;
    assign o_out.last     = r_o_last;

    // accumulator never exceeds its width
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= hep_pkg::CNT_ACC)
        else $error("accumulator count out of range");

    // bits above the pending count stay clear
    a_acc_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_acc >> r_cnt) == '0)
        else $error("stale bits above pending count");

    // a flush with pending bits leaves exactly one padded group
    a_flush_group: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (a_move && (r_a_kind == hep_pkg::KIND_FLUSH) && (rem_cnt != '0))
        |=> (r_cnt == hep_pkg::CNT_GROUP))
        else $error("flush did not form one group");

endmodule
